// ----- src/prefix_code_codec_macros.svh -----
// Assertion macros for the prefix code codec.
`ifndef PREFIX_CODE_CODEC_MACROS_SVH
`define PREFIX_CODE_CODEC_MACROS_SVH

`ifndef SYNTHESIS
`define PCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PCC_ASSERT_SAME(label, ante, cons, msg)
`define PCC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- src/pcc_pkg.sv -----
// Shared types, constants and helpers for the prefix code codec.
package pcc_pkg;

  localparam int NUM_SLOTS    = 64;
  localparam int MAX_CODE_LEN = 16;
  localparam int CODE_W       = 16;
  localparam int LEN_W        = 5;
  localparam int SYM_W        = 8;
  localparam int IDX_W        = 6;
  localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_DECODE = 2'd2
  } req_t;

  typedef enum logic {
    KIND_ENC = 1'b0,
    KIND_DEC = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } slot_wr_t;

  typedef struct packed {
    logic              hit;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } slot_hit_t;

  // Low len bits set; len of CODE_W or more gives all ones.
  function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
    code_mask = ~({CODE_W{1'b1}} << len);
  endfunction

endpackage

// ----- src/prefix_code_codec.sv -----
// Prefix code codec: an accepted beat is held in an input register, matched
// against all table slots in parallel by the 64-way compare and priority select
// of the table, and its result, if any, lands in the output register.
// Sustained rate is one beat per clock while the input does not stall; the input
// stalls only while a beat with a result waits behind a result not yet taken.
// Loads, and decode bits that neither match nor overflow, give no result beat.
// Slot lengths reset to empty at once; no clearing pass is needed.
`include "prefix_code_codec_macros.svh"

module prefix_code_codec (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [5:0] slot_index, [13:6] slot_symbol, [29:14] slot_code, [34:30] slot_length,
  // [42:35] symbol_in, [43] bit_in, [47:44] zero
  input  logic [47:0] s_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] status, [17:2] code_out, [22:18] code_len_out, [30:23] symbol_out, [31] zero
  output logic [31:0] m_tdata,
  // [0] result_kind
  output logic [0:0]  m_tuser
);

  // input register
  logic                         in_valid;
  pcc_pkg::req_t                in_req;
  logic [pcc_pkg::IDX_W-1:0]    in_idx;
  logic [pcc_pkg::SYM_W-1:0]    in_lsym;
  logic [pcc_pkg::CODE_W-1:0]   in_lcode;
  logic [pcc_pkg::LEN_W-1:0]    in_llen;
  logic [pcc_pkg::SYM_W-1:0]    in_esym;
  logic                         in_bit;

  // decode accumulator
  logic [pcc_pkg::CODE_W-1:0]   acc_bits;
  logic [pcc_pkg::LEN_W-1:0]    acc_len;
  logic [pcc_pkg::CODE_W-1:0]   acc_next;
  logic [pcc_pkg::LEN_W-1:0]    alen_next;

  // result register
  pcc_pkg::kind_t               res_kind;
  pcc_pkg::status_t             res_status;
  logic [pcc_pkg::CODE_W-1:0]   res_code;
  logic [pcc_pkg::LEN_W-1:0]    res_len;
  logic [pcc_pkg::SYM_W-1:0]    res_sym;

  pcc_pkg::slot_wr_t            wr;
  pcc_pkg::slot_hit_t           enc_hit;
  pcc_pkg::slot_hit_t           dec_hit;

  logic is_load, is_enc, is_dec;
  logic dec_overflow, emits, advance, in_take;

  assign is_load = (in_req == pcc_pkg::REQ_LOAD);
  assign is_enc  = (in_req == pcc_pkg::REQ_ENCODE);
  assign is_dec  = (in_req == pcc_pkg::REQ_DECODE);

  assign acc_next     = {acc_bits[pcc_pkg::CODE_W-2:0], in_bit};
  assign alen_next    = acc_len + pcc_pkg::LEN_W'(1);
  assign dec_overflow = (alen_next >= pcc_pkg::LEN_W'(pcc_pkg::LEN_CAP));

  assign emits   = is_enc || (is_dec && (dec_hit.hit || dec_overflow));
  assign advance = in_valid && (!emits || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign in_take  = s_tvalid && s_tready;

  always_comb begin
    wr.en   = advance && is_load;
    wr.idx  = in_idx;
    wr.sym  = in_lsym;
    wr.code = in_lcode;
    wr.len  = in_llen;
  end

  pcc_table u_table (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .enc_sym  (in_esym),
    .dec_code (acc_next),
    .dec_len  (alen_next),
    .enc_hit  (enc_hit),
    .dec_hit  (dec_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req   <= pcc_pkg::req_t'(s_tuser);
      in_idx   <= s_tdata[5:0];
      in_lsym  <= s_tdata[13:6];
      in_lcode <= s_tdata[29:14];
      in_llen  <= s_tdata[34:30];
      in_esym  <= s_tdata[42:35];
      in_bit   <= s_tdata[43];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_bits <= '0;
      acc_len  <= '0;
    end else if (advance && is_dec) begin
      if (dec_hit.hit || dec_overflow) begin
        acc_bits <= '0;
        acc_len  <= '0;
      end else begin
        acc_bits <= acc_next;
        acc_len  <= alen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emits) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emits) begin
      if (is_enc) begin
        res_kind <= pcc_pkg::KIND_ENC;
        res_sym  <= in_esym;
        if (enc_hit.hit) begin
          res_status <= pcc_pkg::ST_OK;
          res_code   <= enc_hit.code;
          res_len    <= enc_hit.len;
        end else begin
          res_status <= pcc_pkg::ST_UNKNOWN;
          res_code   <= '0;
          res_len    <= '0;
        end
      end else begin
        res_kind <= pcc_pkg::KIND_DEC;
        res_code <= acc_next;
        res_len  <= alen_next;
        if (dec_hit.hit) begin
          res_status <= pcc_pkg::ST_OK;
          res_sym    <= dec_hit.sym;
        end else begin
          res_status <= pcc_pkg::ST_OVERFLOW;
          res_sym    <= '0;
        end
      end
    end
  end

  assign m_tdata = {1'b0, res_sym, res_len, res_code, res_status};
  assign m_tuser = res_kind;

  `PCC_ASSERT_SAME(a_acc_below_cap, 1'b1, acc_len < pcc_pkg::LEN_W'(pcc_pkg::LEN_CAP), "accumulator length reached cap")
  `PCC_ASSERT_SAME(a_acc_clean, 1'b1, (acc_bits & ~pcc_pkg::code_mask(acc_len)) == '0, "accumulator has bits above its length")
  `PCC_ASSERT_SAME(a_enc_no_overflow, m_tvalid && (res_kind == pcc_pkg::KIND_ENC), res_status != pcc_pkg::ST_OVERFLOW, "encode result with overflow status")
  `PCC_ASSERT_NEXT(a_dec_result_clears, advance && is_dec && (dec_hit.hit || dec_overflow), acc_len == '0, "accumulator not cleared after decode result")

endmodule

// ----- src/pcc_table.sv -----
// Code table: slot storage with parallel symbol and code match.
module pcc_table (
  input  logic                             clk,
  input  logic                             rst,
  input  pcc_pkg::slot_wr_t                wr,
  input  logic [pcc_pkg::SYM_W-1:0]        enc_sym,
  input  logic [pcc_pkg::CODE_W-1:0]       dec_code,
  input  logic [pcc_pkg::LEN_W-1:0]        dec_len,
  output pcc_pkg::slot_hit_t               enc_hit,
  output pcc_pkg::slot_hit_t               dec_hit
);

  logic [pcc_pkg::SYM_W-1:0]  sym_mem  [pcc_pkg::NUM_SLOTS];
  logic [pcc_pkg::CODE_W-1:0] code_mem [pcc_pkg::NUM_SLOTS];
  logic [pcc_pkg::LEN_W-1:0]  len_mem  [pcc_pkg::NUM_SLOTS];

  logic [pcc_pkg::LEN_W-1:0]  wr_len;
  logic [pcc_pkg::CODE_W-1:0] wr_code;

  // overlong lengths empty the slot
  assign wr_len  = (wr.len > pcc_pkg::LEN_W'(pcc_pkg::LEN_CAP)) ? '0 : wr.len;
  assign wr_code = wr.code & pcc_pkg::code_mask(wr_len);

  always_ff @(posedge clk) begin
    for (int i = 0; i < pcc_pkg::NUM_SLOTS; i++) begin
      if (rst) begin
        len_mem[i] <= '0;
      end else if (wr.en && (int'(wr.idx) == i)) begin
        len_mem[i] <= wr_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < pcc_pkg::NUM_SLOTS; i++) begin
      if (wr.en && (int'(wr.idx) == i)) begin
        sym_mem[i]  <= wr.sym;
        code_mem[i] <= wr_code;
      end
    end
  end

  // later slots override earlier ones: highest index wins
  always_comb begin
    enc_hit = '0;
    dec_hit = '0;
    for (int i = 0; i < pcc_pkg::NUM_SLOTS; i++) begin
      if ((len_mem[i] != '0) && (sym_mem[i] == enc_sym)) begin
        enc_hit.hit  = 1'b1;
        enc_hit.sym  = sym_mem[i];
        enc_hit.code = code_mem[i];
        enc_hit.len  = len_mem[i];
      end
      if ((len_mem[i] != '0) && (len_mem[i] == dec_len) && (code_mem[i] == dec_code)) begin
        dec_hit.hit  = 1'b1;
        dec_hit.sym  = sym_mem[i];
        dec_hit.code = code_mem[i];
        dec_hit.len  = len_mem[i];
      end
    end
  end

endmodule
